>>> rtl/sort_and_remove_duplicates_core_macros.svh
// assertion macros for the sorting de-duplicator
// used by rtl/sort_and_remove_duplicates_core.sv; expects aclk and aresetn in scope
`ifndef SORT_AND_REMOVE_DUPLICATES_CORE_MACROS_SVH
`define SORT_AND_REMOVE_DUPLICATES_CORE_MACROS_SVH

// same-cycle implication
`define SADC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SADC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sadc_pkg.sv
// types shared by the sorting de-duplicator
// no dependencies
package sadc_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflowed;
    } out_t;

    typedef struct packed {
        logic               ins;
        logic               pop;
        logic signed [31:0] key;
    } ctl_t;

    typedef struct packed {
        logic               valid;
        logic               gt;
        logic signed [31:0] data;
    } link_t;

endpackage

>>> rtl/sort_and_remove_duplicates_core.sv
// Sorting de-duplicator: takes signed 32-bit values one per cycle while s_ready is high,
// and keeps the distinct ones in ascending order in a chain of DEPTH cells that all
// compare against the incoming value at once. After the request flagged last_in is taken,
// the chain drains one value per cycle through the output register while the output is
// not stalled, smallest first, with last_out on the largest and overflowed set if distinct
// values beyond DEPTH were dropped (the largest go). While draining, s_ready is low, so a
// new list waits until all held values (at most DEPTH) have left. Depends on sadc_pkg and
// sort_and_remove_duplicates_core_macros.svh.
module sort_and_remove_duplicates_core #(
    parameter int DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sadc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sadc_pkg::out_t m_data
);
    import sadc_pkg::*;
    `include "sort_and_remove_duplicates_core_macros.svh"

    localparam link_t EMPTY_LINK = '{valid: 1'b0, gt: 1'b0, data: '0};

    link_t              links [DEPTH];
    logic [DEPTH-1:0]   hits;
    logic [DEPTH-1:0]   cell_valid;
    ctl_t               ctl;
    logic               s_fire, dup, pop;
    logic               drain_reg, drain_next;
    logic               ovf_reg, ovf_next;
    logic               drain_ovf_reg, drain_ovf_next;
    logic               m_valid_reg, m_valid_next;
    out_t               out_reg, out_next;

    assign s_ready = !drain_reg;
    assign s_fire  = s_valid && s_ready;
    assign dup     = |hits;
    assign pop     = drain_reg && links[0].valid && (!m_valid_reg || m_ready);

    assign ctl.ins = s_fire && !dup;
    assign ctl.pop = pop;
    assign ctl.key = s_data.value;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            link_t prev_l, next_l;
            if (i == 0) begin : g_first
                assign prev_l = EMPTY_LINK;
            end else begin : g_mid
                assign prev_l = links[i-1];
            end
            if (i == DEPTH - 1) begin : g_end
                assign next_l = EMPTY_LINK;
            end else begin : g_inner
                assign next_l = links[i+1];
            end
            sadc_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .prev_link (prev_l),
                .next_link (next_l),
                .own_link  (links[i]),
                .hit       (hits[i])
            );
            assign cell_valid[i] = links[i].valid;
        end
    endgenerate

    always_comb begin
        ovf_next       = ovf_reg;
        drain_ovf_next = drain_ovf_reg;
        drain_next     = drain_reg;
        if (s_fire) begin
            ovf_next = ovf_reg || (!dup && links[DEPTH-1].valid);
            if (s_data.last_in) begin
                drain_ovf_next = ovf_next;
                ovf_next       = 1'b0;
                drain_next     = 1'b1;
            end
        end
        if (pop && !links[1].valid) begin
            drain_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (pop) begin
            m_valid_next          = 1'b1;
            out_next.sorted_value = links[0].data;
            out_next.last_out     = !links[1].valid;
            out_next.overflowed   = drain_ovf_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            drain_ovf_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            drain_reg     <= drain_next;
            ovf_reg       <= ovf_next;
            drain_ovf_reg <= drain_ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // occupied cells always form a prefix of the chain
    `SADC_ASSERT_NOW(a_valid_prefix, 1'b1, (cell_valid & (cell_valid + DEPTH'(1))) == '0, "cell gap")
    // the final request leaves at least one value to drain
    `SADC_ASSERT_NEXT(a_last_drains, s_fire && s_data.last_in, drain_reg && cell_valid[0], "empty drain")
    // a stalled result holds
    `SADC_ASSERT_NEXT(a_out_hold, m_valid_reg && !m_ready, m_valid_reg && $stable(out_reg), "result moved")
    // nothing drains unless a final request started it
    `SADC_ASSERT_NEXT(a_idle_stays, !drain_reg && !(s_fire && s_data.last_in), !drain_reg, "bad drain")

endmodule

>>> rtl/sadc_cell.sv
// one slot of the sorting chain: holds a value and shifts toward either neighbor
// depends on sadc_pkg
module sadc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  sadc_pkg::ctl_t  ctl,
    input  sadc_pkg::link_t prev_link,
    input  sadc_pkg::link_t next_link,
    output sadc_pkg::link_t own_link,
    output logic            hit
);
    import sadc_pkg::*;

    logic               valid_reg, valid_next;
    logic signed [31:0] data_reg, data_next;
    logic               gt;

    assign gt  = !valid_reg || (data_reg > ctl.key);
    assign hit = valid_reg && (data_reg == ctl.key);

    assign own_link.valid = valid_reg;
    assign own_link.gt    = gt;
    assign own_link.data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.pop) begin
            valid_next = next_link.valid;
            data_next  = next_link.data;
        end else if (ctl.ins && gt) begin
            if (prev_link.gt) begin
                valid_next = prev_link.valid;
                data_next  = prev_link.data;
            end else begin
                valid_next = 1'b1;
                data_next  = ctl.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

>>> sim/sadc_checker.sv
// result checker for the sorting de-duplicator: watches both channels, keeps its own
// sorted store and compares every result with the queue of expected ones
// depends on sadc_pkg
`timescale 1ns / 100ps

module sadc_checker #(
    parameter int DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  sadc_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  sadc_pkg::out_t m_data,
    output int             fail_count,
    output int             expected_left
);

    logic signed [31:0] held_vals [DEPTH];
    int                 held_n;
    bit                 drop_seen;
    int                 fails;
    sadc_pkg::out_t     sorted_expect [$];

    initial begin
        fail_count    = 0;
        expected_left = 0;
        fails         = 0;
        held_n        = 0;
        drop_seen     = 1'b0;
    end

    always @(posedge aclk) begin : watch
        int                 pos;
        int                 k;
        bit                 keep;
        logic signed [31:0] v;
        sadc_pkg::out_t     got;
        sadc_pkg::out_t     want;
        sadc_pkg::out_t     res;
        if (!aresetn) begin
            held_n    = 0;
            drop_seen = 1'b0;
            sorted_expect.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (sorted_expect.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result value=%0d last=%b ovf=%b", $time,
                             got.sorted_value, got.last_out, got.overflowed);
                end else begin
                    want = sorted_expect.pop_front();
                    if (got.sorted_value !== want.sorted_value ||
                        got.last_out !== want.last_out ||
                        got.overflowed !== want.overflowed) begin
                        fails++;
                        $display("%0t: mismatch expected value=%0d last=%b ovf=%b,",
                                 $time, want.sorted_value, want.last_out, want.overflowed,
                                 " got value=%0d last=%b ovf=%b",
                                 got.sorted_value, got.last_out, got.overflowed);
                    end
                end
            end
            if (s_valid && s_ready) begin
                v   = s_data.value;
                pos = 0;
                while (pos < held_n && held_vals[pos] < v)
                    pos++;
                if (!(pos < held_n && held_vals[pos] == v)) begin
                    keep = 1'b1;
                    if (held_n >= DEPTH) begin
                        drop_seen = 1'b1;
                        if (pos >= DEPTH)
                            keep = 1'b0;
                        else
                            held_n = DEPTH - 1;
                    end
                    if (keep) begin
                        for (k = held_n; k > pos; k--)
                            held_vals[k] = held_vals[k - 1];
                        held_vals[pos] = v;
                        held_n++;
                    end
                end
                if (s_data.last_in) begin
                    for (k = 0; k < held_n; k++) begin
                        res.sorted_value = held_vals[k];
                        res.last_out     = (k == held_n - 1);
                        res.overflowed   = drop_seen;
                        sorted_expect.push_back(res);
                    end
                    held_n    = 0;
                    drop_seen = 1'b0;
                end
            end
        end
        fail_count    <= fails;
        expected_left <= sorted_expect.size();
    end

endmodule

>>> sim/testbench.sv
// top of the sorting de-duplicator test: clock, reset, request lists and result stalls
// depends on sadc_pkg, sort_and_remove_duplicates_core and sadc_checker
`timescale 1ns / 100ps

module testbench;

    localparam int                 DEPTH     = 16;
    localparam int                 RAND_ITEMS = 260;
    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    sadc_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    sadc_pkg::out_t m_data;
    int             fail_count;
    int             expected_left;
    int             burst_left;
    int             items_sent;

    sort_and_remove_duplicates_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    sadc_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .fail_count(fail_count),
        .expected_left(expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic offer(input logic signed [31:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_data  <= '{value: v, last_in: l};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_list(input logic signed [31:0] vals [$]);
        foreach (vals[i])
            offer(vals[i], i == vals.size() - 1);
    endtask

    function automatic logic signed [31:0] pick_value(input logic signed [31:0] prev);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 8) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return prev;
        endcase
    endfunction

    // receiver: phases of random stall density, one long hold-off
    initial begin : receiver
        int  run;
        int  mode;
        int  cyc;
        bit  hold_done;
        m_ready   = 1'b0;
        cyc       = 0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            run  = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (run) begin
                @(negedge aclk);
                cyc++;
                if (!hold_done && cyc > 600) begin
                    m_ready <= 1'b0;
                    repeat (300) @(negedge aclk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= $urandom_range(0, 1);
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= cyc[0];
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        logic signed [31:0] vals [$];
        logic signed [31:0] prev;
        int                 len;
        int                 kind;
        s_valid    = 1'b0;
        s_data     = '0;
        aresetn    = 1'b0;
        burst_left = 0;
        items_sent = 0;
        prev       = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_list('{VAL_MIN});
        send_list('{VAL_MAX});
        send_list('{32'sd0});
        send_list('{-32'sd1});
        send_list('{32'sd7, 32'sd7, -32'sd3, 32'sd7});
        // fill the store, then one value above all held and one below
        vals.delete();
        for (int i = 1; i <= DEPTH; i++)
            vals.push_back(i);
        vals.push_back(100);
        vals.push_back(-100);
        send_list(vals);

        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            vals.delete();
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    prev = pick_value(prev);
                    vals.push_back(prev);
                end
            end else if (kind < 8) begin
                len = $urandom_range(DEPTH + 1, DEPTH + 14);
                repeat (len) begin
                    if ($urandom_range(0, 7) == 0 && vals.size() > 0)
                        vals.push_back(vals[$urandom_range(0, vals.size() - 1)]);
                    else
                        vals.push_back($urandom);
                end
            end else begin
                vals.push_back($urandom);
            end
            send_list(vals);
        end

        s_valid <= 1'b0;
        while (expected_left != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sadc_pkg.sv
rtl/sadc_cell.sv
rtl/sort_and_remove_duplicates_core.sv
sim/sadc_checker.sv
sim/testbench.sv
